[src/gni_pkg.sv]
`default_nettype none
package gni_pkg;

  // Axes wired through the datapath; MAX_DIMS can only lower the count in use.
  localparam int AXES     = 4;
  localparam int MAX_DIMS = 4;
  localparam int USED_MAX = (MAX_DIMS < AXES) ? MAX_DIMS : AXES;

  localparam int CRD_W  = 8;
  localparam int LEN_W  = 9;
  localparam int STEP_W = 4;
  localparam int DIM_W  = 3;
  localparam int IDX_W  = 32;
  // Signed working width for a moved coordinate and for length minus one.
  localparam int CW     = LEN_W + 2;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_W  = 3;

  localparam logic [2:0] OP_PLAIN   = 3'd0;
  localparam logic [2:0] OP_OFFSET  = 3'd1;
  localparam logic [2:0] OP_UP      = 3'd2;
  localparam logic [2:0] OP_DOWN    = 3'd3;
  localparam logic [2:0] OP_CLAMPED = 3'd4;
  localparam logic [2:0] OP_TRANS   = 3'd5;

  localparam logic [REG_W-1:0] REG_DIMS = 3'd0;
  localparam logic [REG_W-1:0] REG_LEN0 = 3'd1;
  localparam logic [REG_W-1:0] REG_LEN1 = 3'd2;
  localparam logic [REG_W-1:0] REG_LEN2 = 3'd3;
  localparam logic [REG_W-1:0] REG_LEN3 = 3'd4;

  typedef struct packed {
    logic [2:0]               op;
    logic [CRD_W-1:0]         coord_0;
    logic [CRD_W-1:0]         coord_1;
    logic [CRD_W-1:0]         coord_2;
    logic [CRD_W-1:0]         coord_3;
    logic [1:0]               axis_sel;
    logic signed [STEP_W-1:0] offset;
    logic signed [STEP_W-1:0] step_0;
    logic signed [STEP_W-1:0] step_1;
    logic signed [STEP_W-1:0] step_2;
    logic signed [STEP_W-1:0] step_3;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] lin_index;
    logic             overrun;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]             dims_used;
    logic [AXES-1:0][LEN_W-1:0]   axis_len;
  } cfg_t;

  // One beat in the index pipeline: checked coordinates and the partial sum.
  typedef struct packed {
    logic                         over;
    logic [AXES-1:0][LEN_W-1:0]   coord;
    logic [IDX_W-1:0]             acc;
  } pipe_t;

endpackage
`default_nettype wire

[src/gni_cfg.sv]
`default_nettype none
module gni_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gni_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gni_pkg::DATA_W-1:0]  pwdata,
  output logic      [gni_pkg::DATA_W-1:0]  prdata,
  output gni_pkg::cfg_t                    cfg
);

  logic [gni_pkg::DIM_W-1:0]                     dims_used;
  logic [gni_pkg::AXES-1:0][gni_pkg::LEN_W-1:0]  axis_len;
  logic [gni_pkg::REG_W-1:0]                     reg_idx;
  logic                                          wr;

  assign reg_idx = paddr[gni_pkg::ADDR_W-1:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used <= gni_pkg::DIM_W'(1);
      for (int k = 0; k < gni_pkg::AXES; k++) begin
        axis_len[k] <= gni_pkg::LEN_W'(2);
      end
    end else if (wr) begin
      unique case (reg_idx)
        gni_pkg::REG_DIMS: dims_used   <= pwdata[gni_pkg::DIM_W-1:0];
        gni_pkg::REG_LEN0: axis_len[0] <= pwdata[gni_pkg::LEN_W-1:0];
        gni_pkg::REG_LEN1: axis_len[1] <= pwdata[gni_pkg::LEN_W-1:0];
        gni_pkg::REG_LEN2: axis_len[2] <= pwdata[gni_pkg::LEN_W-1:0];
        gni_pkg::REG_LEN3: axis_len[3] <= pwdata[gni_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gni_pkg::REG_DIMS: prdata = gni_pkg::DATA_W'(dims_used);
      gni_pkg::REG_LEN0: prdata = gni_pkg::DATA_W'(axis_len[0]);
      gni_pkg::REG_LEN1: prdata = gni_pkg::DATA_W'(axis_len[1]);
      gni_pkg::REG_LEN2: prdata = gni_pkg::DATA_W'(axis_len[2]);
      gni_pkg::REG_LEN3: prdata = gni_pkg::DATA_W'(axis_len[3]);
      default:           prdata = '0;
    endcase
  end

  assign cfg.dims_used = dims_used;
  assign cfg.axis_len  = axis_len;

endmodule
`default_nettype wire

[src/gni_move.sv]
`default_nettype none
module gni_move (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gni_pkg::cfg_t    cfg,
  input  wire gni_pkg::item_t   item,
  input  wire logic             item_valid,
  output logic                  item_ready,
  output gni_pkg::pipe_t        dn,
  output logic                  dn_valid,
  input  wire logic             dn_ready
);

  gni_pkg::item_t  held;
  logic            held_valid;
  logic            adv;
  gni_pkg::pipe_t  dn_next;

  logic [gni_pkg::AXES-1:0][gni_pkg::CRD_W-1:0]  crd;
  logic [gni_pkg::AXES-1:0][gni_pkg::STEP_W-1:0] stp;
  logic signed [gni_pkg::CW-1:0] cv   [gni_pkg::AXES];
  logic signed [gni_pkg::CW-1:0] lenv [gni_pkg::AXES];
  logic signed [gni_pkg::CW-1:0] sv   [gni_pkg::AXES];
  logic signed [gni_pkg::CW-1:0] offv;
  logic [gni_pkg::AXES-1:0]      used;
  logic [gni_pkg::AXES-1:0]      bad;
  logic [gni_pkg::DIM_W-1:0]     n_used;

  assign adv        = !dn_valid || dn_ready;
  assign item_ready = !held_valid || adv;

  assign crd = {held.coord_3, held.coord_2, held.coord_1, held.coord_0};
  assign stp = {held.step_3, held.step_2, held.step_1, held.step_0};

  always_comb begin
    if (cfg.dims_used == '0) begin
      n_used = gni_pkg::DIM_W'(1);
    end else if (cfg.dims_used > gni_pkg::DIM_W'(gni_pkg::USED_MAX)) begin
      n_used = gni_pkg::DIM_W'(gni_pkg::USED_MAX);
    end else begin
      n_used = cfg.dims_used;
    end
  end

  always_comb begin
    offv = {{(gni_pkg::CW-gni_pkg::STEP_W){held.offset[gni_pkg::STEP_W-1]}}, held.offset};
    for (int k = 0; k < gni_pkg::AXES; k++) begin
      cv[k]   = {{(gni_pkg::CW-gni_pkg::CRD_W){1'b0}}, crd[k]};
      lenv[k] = {{(gni_pkg::CW-gni_pkg::LEN_W){1'b0}}, cfg.axis_len[k]};
      sv[k]   = {{(gni_pkg::CW-gni_pkg::STEP_W){stp[k][gni_pkg::STEP_W-1]}}, stp[k]};
      case (held.op)
        gni_pkg::OP_OFFSET: begin
          if (held.axis_sel == 2'(k)) cv[k] = cv[k] + offv;
        end
        gni_pkg::OP_UP: begin
          if (held.axis_sel == 2'(k) && cv[k] != lenv[k] - gni_pkg::CW'(1)) begin
            cv[k] = cv[k] + gni_pkg::CW'(1);
          end
        end
        gni_pkg::OP_DOWN: begin
          if (held.axis_sel == 2'(k) && cv[k] != '0) begin
            cv[k] = cv[k] - gni_pkg::CW'(1);
          end
        end
        gni_pkg::OP_CLAMPED: begin
          cv[k] = cv[k] + sv[k];
          if (cv[k] < 0) begin
            cv[k] = '0;
          end else if (cv[k] == lenv[k]) begin
            cv[k] = lenv[k] - gni_pkg::CW'(1);
          end
        end
        gni_pkg::OP_TRANS: cv[k] = cv[k] + sv[k];
        default: ;
      endcase
      used[k] = gni_pkg::DIM_W'(k) < n_used;
      bad[k]  = used[k] && (cv[k] < 0 || cv[k] >= lenv[k]);
    end
  end

  always_comb begin
    dn_next.over = |bad;
    for (int k = 0; k < gni_pkg::AXES; k++) begin
      dn_next.coord[k] = (used[k] && !dn_next.over) ? cv[k][gni_pkg::LEN_W-1:0] : '0;
    end
    dn_next.acc = gni_pkg::IDX_W'(dn_next.coord[gni_pkg::AXES-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      dn_valid   <= 1'b0;
    end else begin
      if (item_ready) held_valid <= item_valid;
      if (adv)        dn_valid   <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) held <= item;
    if (adv && held_valid)        dn   <= dn_next;
  end

endmodule
`default_nettype wire

[src/gni_horner.sv]
`default_nettype none
module gni_horner (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gni_pkg::pipe_t             up,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire logic [gni_pkg::LEN_W-1:0]  coord,
  input  wire logic [gni_pkg::LEN_W-1:0]  len,
  output gni_pkg::pipe_t                  dn,
  output logic                            dn_valid,
  input  wire logic                       dn_ready
);

  logic [gni_pkg::LEN_W+gni_pkg::IDX_W-1:0] prod;
  gni_pkg::pipe_t                           dn_next;

  assign up_ready = !dn_valid || dn_ready;
  assign prod     = len * up.acc;

  always_comb begin
    dn_next     = up;
    dn_next.acc = up.over ? '0
                : gni_pkg::IDX_W'(coord) + prod[gni_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) dn <= dn_next;
  end

endmodule
`default_nettype wire

[src/grid_neighbor_index_top.sv]
// Grid neighbor index: row-major linear index of a moved grid point, axis zero fastest.
// An item beat passes the input register, the move stage register and the three Horner stage registers in order.
// Throughput: one item per cycle; each of the three Horner stages holds one 9 x 32 multiply.
// Every stage stalls only while its own output is held, so bubbles close up under backpressure.
// Reset (rst, synchronous, active high) empties the pipeline and sets dims_used to one
// and every axis length to two.
`default_nettype none
module grid_neighbor_index_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire gni_pkg::item_t              item,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output gni_pkg::result_t                 result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gni_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gni_pkg::DATA_W-1:0]  pwdata,
  output logic      [gni_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  gni_pkg::cfg_t                   cfg;
  gni_pkg::pipe_t                  pipe [gni_pkg::AXES];
  logic [gni_pkg::AXES-1:0]        vld;
  logic [gni_pkg::AXES-1:0]        rdy;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  gni_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Input register, then the move and range check. Coordinates of unused axes
  // leave this stage as zero, so the Horner chain below needs no dimension count,
  // and an overrun zeroes them all.
  gni_move u_move (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .dn         (pipe[0]),
    .dn_valid   (vld[0]),
    .dn_ready   (rdy[0])
  );

  // Horner evaluation from the highest axis down:
  // acc = c[k] + len[k] * acc, one axis per registered stage.
  for (genvar m = 1; m < gni_pkg::AXES; m++) begin : g_horner
    localparam int K = gni_pkg::AXES - 1 - m;
    gni_horner u_horner (
      .clk      (clk),
      .rst      (rst),
      .up       (pipe[m-1]),
      .up_valid (vld[m-1]),
      .up_ready (rdy[m-1]),
      .coord    (pipe[m-1].coord[K]),
      .len      (cfg.axis_len[K]),
      .dn       (pipe[m]),
      .dn_valid (vld[m]),
      .dn_ready (rdy[m])
    );
  end

  // The last stage register is the output register; its sum is already zero on overrun.
  assign rdy[gni_pkg::AXES-1] = result_ready;
  assign result_valid         = vld[gni_pkg::AXES-1];
  assign result.lin_index     = pipe[gni_pkg::AXES-1].acc;
  assign result.overrun       = pipe[gni_pkg::AXES-1].over;

endmodule
`default_nettype wire

[src/gni_checker.sv]
`default_nettype none
module gni_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire gni_pkg::result_t            result,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [gni_pkg::ADDR_W-1:0]  paddr,
  input wire logic [gni_pkg::DATA_W-1:0]  pwdata,
  input wire logic [gni_pkg::DATA_W-1:0]  prdata,
  input wire logic                        pready
);

  // A stalled result beat keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // An overrun always comes with a zero index.
  a_overrun_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overrun |-> result.lin_index == '0)
    else $error("overrun result carries a nonzero index");

  // With no result waiting, every stage can move, so an item beat is taken.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled while the output is free");

  // A write to dims_used reads back on the next cycle.
  a_dims_readback: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(psel && penable && pwrite && pready && paddr == '0)
      && paddr == '0
      |-> prdata[gni_pkg::DIM_W-1:0] == $past(pwdata[gni_pkg::DIM_W-1:0]))
    else $error("dims_used readback mismatch");

endmodule

bind grid_neighbor_index_top gni_checker u_gni_checker (.*);
`default_nettype wire
